/* sv/afp_pkg.sv */
// ============================================================================
// afp_pkg - shared definitions of the addressed frame parser
// Item types, configuration layout, sizing constants and the CRC-16 step
// used by the parser front end and the delivery back end.
// ============================================================================
package afp_pkg;

    // Frame layout and buffering.
    localparam int ADDR_BYTES  = 4;
    localparam int MAX_PAYLOAD = 32;
    localparam int CHECK_BYTES = 2;

    // Payload index width; one bank holds MAX_PAYLOAD bytes, two banks in all.
    localparam int PL_IW     = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int RAM_AW    = PL_IW + 1;
    localparam int RAM_DEPTH = 2 ** RAM_AW;

    // Field counter of the parser.
    localparam int FC_W = 7;

    // Result queue of the back end.
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = 2;
    localparam int OQ_CW    = 3;

    // Address bytes that take part in the comparison with the own address.
    localparam logic [31:0] ADDR_MASK = (ADDR_BYTES >= 4) ? 32'hFFFF_FFFF :
        32'((64'd1 << (8 * ADDR_BYTES)) - 64'd1);

    // Reflected CCITT polynomial.
    localparam logic [15:0] CRC_POLY = 16'h8408;

    // Item kinds.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Configuration register indexes.
    localparam int CFG_IW = 3;
    localparam logic [CFG_IW-1:0] REG_HEADER    = 3'd0;
    localparam logic [CFG_IW-1:0] REG_CRC_START = 3'd1;
    localparam logic [CFG_IW-1:0] REG_RESIDUE   = 3'd2;
    localparam logic [CFG_IW-1:0] REG_GAP_LIMIT = 3'd3;
    localparam logic [CFG_IW-1:0] REG_OWN_ADDR  = 3'd4;

    // Configuration reset values.
    localparam logic [7:0]  RST_HEADER    = 8'h00;
    localparam logic [15:0] RST_CRC_START = 16'hFFFF;
    localparam logic [15:0] RST_RESIDUE   = 16'hF0B8;
    localparam logic [15:0] RST_GAP_LIMIT = 16'd500;
    localparam logic [31:0] RST_OWN_ADDR  = 32'h0000_0000;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [31:0] frame_address;
        logic        address_match;
        logic [7:0]  frame_length;
        logic [7:0]  frame_command;
        logic [7:0]  payload_byte;
        logic [5:0]  payload_index;
        logic        last_of_frame;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  header_value;
        logic [15:0] crc_start;
        logic [15:0] crc_good_residue;
        logic [15:0] gap_limit_ticks;
        logic [31:0] own_address;
    } t_cfg;

    // Header of one good frame waiting for delivery.
    typedef struct packed {
        logic [31:0] addr;
        logic        match;
        logic [7:0]  len;
        logic [7:0]  cmd;
    } t_desc;

    // Payload memory write request.
    typedef struct packed {
        logic              we;
        logic [RAM_AW-1:0] addr;
        logic [7:0]        data;
    } t_pl_wr;

    // One byte through the reflected CRC-16, one bit per step.
    function automatic logic [15:0] crc_upd(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

/* sv/afp_ram.sv */
// ============================================================================
// afp_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ============================================================================
module afp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* sv/afp_front.sv */
// ============================================================================
// afp_front - frame parser front end
// Takes bytes and ticks, runs the CRC, stores payload into the current bank
// and posts the header of each good frame to the delivery queue.
// ============================================================================
module afp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  afp_pkg::t_in_item i_item,
    input  afp_pkg::t_cfg     i_cfg,
    input  logic              i_bank,
    output afp_pkg::t_pl_wr   o_pl_wr,
    output logic              o_desc_push,
    output afp_pkg::t_desc    o_desc
);
    import afp_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_ADDR    = 6'b000010,
        ST_LENGTH  = 6'b000100,
        ST_CMD     = 6'b001000,
        ST_PAYLOAD = 6'b010000,
        ST_CHECK   = 6'b100000
    } t_phase;

    t_phase          r_phase, n_phase;
    logic [FC_W-1:0] r_fc, n_fc;
    logic [15:0]     r_crc, n_crc;
    logic [31:0]     r_addr, n_addr;
    logic [7:0]      r_len, n_len;
    logic [7:0]      r_cmd, n_cmd;
    logic [15:0]     r_idle, n_idle;

    logic            in_frame;
    logic            fresh;
    logic [FC_W-1:0] fc_inc;
    logic [15:0]     crc_nx;
    logic [7:0]      rx;

    assign rx       = i_item.rx_byte;
    assign in_frame = (r_phase == ST_ADDR) || (r_phase == ST_LENGTH) || (r_phase == ST_CMD) ||
                      (r_phase == ST_PAYLOAD) || (r_phase == ST_CHECK);
    // A byte after too long a gap starts over, as does any byte outside a frame.
    assign fresh    = !in_frame || (r_idle > i_cfg.gap_limit_ticks);
    assign fc_inc   = r_fc + FC_W'(1);
    assign crc_nx   = crc_upd(fresh ? i_cfg.crc_start : r_crc, rx);

    assign o_desc.addr  = r_addr;
    assign o_desc.match = ((r_addr ^ i_cfg.own_address) & ADDR_MASK) == 32'd0;
    assign o_desc.len   = r_len;
    assign o_desc.cmd   = r_cmd;

    always_comb begin
        n_phase      = r_phase;
        n_fc         = r_fc;
        n_crc        = r_crc;
        n_addr       = r_addr;
        n_len        = r_len;
        n_cmd        = r_cmd;
        n_idle       = r_idle;
        o_desc_push  = 1'b0;
        o_pl_wr.we   = 1'b0;
        o_pl_wr.addr = {i_bank, r_fc[PL_IW-1:0]};
        o_pl_wr.data = rx;
        if (i_accept) begin
            if (i_item.kind == KIND_TICK) begin
                if (r_idle != 16'hFFFF) begin
                    n_idle = r_idle + 16'd1;
                end
            end else begin
                n_idle = 16'd0;
                n_crc  = crc_nx;
                if (fresh) begin
                    n_addr  = 32'd0;
                    n_len   = 8'd0;
                    n_cmd   = 8'd0;
                    n_fc    = '0;
                    n_phase = (rx == i_cfg.header_value) ? ST_ADDR : ST_IDLE;
                end else begin
                    case (r_phase)
                        ST_ADDR: begin
                            for (int i = 0; i < 4; i++) begin
                                if (r_fc == FC_W'(i)) begin
                                    n_addr[8*i +: 8] = rx;
                                end
                            end
                            n_fc = fc_inc;
                            if (fc_inc >= FC_W'(ADDR_BYTES)) begin
                                n_fc    = '0;
                                n_phase = ST_LENGTH;
                            end
                        end
                        ST_LENGTH: begin
                            n_len   = rx;
                            n_phase = ST_CMD;
                        end
                        ST_CMD: begin
                            n_cmd   = rx;
                            n_phase = (r_len != 8'd0) ? ST_PAYLOAD : ST_CHECK;
                        end
                        ST_PAYLOAD: begin
                            o_pl_wr.we = (r_fc < FC_W'(MAX_PAYLOAD));
                            n_fc       = fc_inc;
                            if ((8'(fc_inc) >= r_len) || (fc_inc >= FC_W'(MAX_PAYLOAD))) begin
                                n_fc    = '0;
                                n_phase = ST_CHECK;
                            end
                        end
                        ST_CHECK: begin
                            n_fc = fc_inc;
                            if (fc_inc >= FC_W'(CHECK_BYTES)) begin
                                n_fc        = '0;
                                n_phase     = ST_IDLE;
                                o_desc_push = (crc_nx == i_cfg.crc_good_residue);
                            end
                        end
                        default: begin
                            n_phase = ST_IDLE;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ST_IDLE;
            r_fc    <= '0;
            r_crc   <= RST_CRC_START;
            r_addr  <= 32'd0;
            r_len   <= 8'd0;
            r_cmd   <= 8'd0;
            r_idle  <= 16'd0;
        end else begin
            r_phase <= n_phase;
            r_fc    <= n_fc;
            r_crc   <= n_crc;
            r_addr  <= n_addr;
            r_len   <= n_len;
            r_cmd   <= n_cmd;
            r_idle  <= n_idle;
        end
    end

endmodule

/* sv/afp_back.sv */
// ============================================================================
// afp_back - frame delivery back end
// Walks the payload of the oldest waiting frame, one memory read per cycle
// while the queue has room; one result per stored byte, one for an empty frame.
// ============================================================================
module afp_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_desc_valid,
    input  afp_pkg::t_desc             i_desc,
    input  logic                       i_bank,
    input  logic [7:0]                 i_rdata,
    input  logic                       i_pop,
    output logic [afp_pkg::RAM_AW-1:0] o_raddr,
    output logic                       o_desc_pop,
    output logic                       o_empty,
    output afp_pkg::t_out_item         o_result
);
    import afp_pkg::*;

    logic [PL_IW-1:0] r_k;
    logic             r_infl;
    t_out_item        r_meta;
    logic             r_zero;

    t_out_item        r_q [OQ_DEPTH];
    logic [OQ_AW-1:0] r_wp, r_rp;
    logic [OQ_CW-1:0] r_cnt;

    logic [7:0]       k1;
    logic             last;
    logic             issue;
    logic             do_pop;
    t_out_item        wr_item;

    assign k1    = 8'(r_k) + 8'd1;
    assign last  = (i_desc.len == 8'd0) || (k1 == i_desc.len) || (k1 == 8'(MAX_PAYLOAD));
    // Issue a read only when the result queue has room for everything in flight.
    assign issue = i_desc_valid && ((r_cnt + OQ_CW'(r_infl)) < OQ_CW'(OQ_DEPTH));
    assign do_pop = i_pop && (r_cnt != '0);

    assign o_raddr    = {i_bank, r_k};
    assign o_desc_pop = issue && last;
    assign o_empty    = (r_cnt == '0);
    assign o_result   = r_q[r_rp];

    always_comb begin
        wr_item = r_meta;
        wr_item.payload_byte = r_zero ? 8'd0 : i_rdata;
    end

    always_ff @(posedge i_clk) begin
        r_meta.frame_address <= i_desc.addr;
        r_meta.address_match <= i_desc.match;
        r_meta.frame_length  <= i_desc.len;
        r_meta.frame_command <= i_desc.cmd;
        r_meta.payload_byte  <= 8'd0;
        r_meta.payload_index <= 6'(r_k);
        r_meta.last_of_frame <= last;
        r_zero               <= (i_desc.len == 8'd0);
        if (r_infl) begin
            r_q[r_wp] <= wr_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k    <= '0;
            r_infl <= 1'b0;
            r_wp   <= '0;
            r_rp   <= '0;
            r_cnt  <= '0;
        end else begin
            r_infl <= issue;
            if (issue) begin
                r_k <= last ? '0 : r_k + PL_IW'(1);
            end
            if (r_infl) begin
                r_wp <= r_wp + OQ_AW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + OQ_AW'(1);
            end
            r_cnt <= r_cnt + OQ_CW'(r_infl) - OQ_CW'(do_pop);
        end
    end

endmodule

/* sv/addressed_frame_parser_crc16.sv */
// ============================================================================
// addressed_frame_parser_crc16 - addressed serial frame parser with CRC-16
// Parses header, address, length, command, payload and check bytes and
// delivers the payload of every frame that passes the X.25 CRC check.
// ============================================================================
// Items are received bytes and one-millisecond ticks; the parser accepts one
// item per cycle on push while full is low. The CRC runs over every byte of
// a frame, header and check bytes included, and a frame is good when it ends
// at the configured residue. A byte that arrives after more idle ticks than
// the gap limit drops the partial frame and is taken as a new header attempt.
// A good frame comes out as one item per stored payload byte (at most
// MAX_PAYLOAD of them) or as one item when its length is zero, at one item
// per cycle, set by the single read port of the payload memory, while the
// result queue has room. That memory holds two banks, so one frame can be
// parsed while the previous one is still being delivered; full is high while
// two good frames wait, and both bytes and ticks are held off until the older
// one has been read out of the memory. The user must write configuration
// through the register port only while the block is idle; it is not enforced.
module addressed_frame_parser_crc16 (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  afp_pkg::t_in_item          i_item,
    output logic                       empty,
    input  logic                       pop,
    output afp_pkg::t_out_item         o_result,
    input  logic                       i_cfg_we,
    input  logic [afp_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [31:0]                i_cfg_wdata
);
    import afp_pkg::*;

    t_cfg              r_cfg;

    // Queue of good-frame headers; slot k owns payload bank k.
    t_desc             r_dq [2];
    logic              r_dq_wp, r_dq_rp;
    logic [1:0]        r_dq_cnt;

    logic              accept;
    logic              dq_push, dq_pop;
    t_desc             front_desc;
    t_pl_wr            pl_wr;
    logic [RAM_AW-1:0] raddr;
    logic [7:0]        rdata;

    assign full   = (r_dq_cnt == 2'd2);
    assign accept = push && !full;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_value     <= RST_HEADER;
            r_cfg.crc_start        <= RST_CRC_START;
            r_cfg.crc_good_residue <= RST_RESIDUE;
            r_cfg.gap_limit_ticks  <= RST_GAP_LIMIT;
            r_cfg.own_address      <= RST_OWN_ADDR;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_HEADER:    r_cfg.header_value     <= i_cfg_wdata[7:0];
                REG_CRC_START: r_cfg.crc_start        <= i_cfg_wdata[15:0];
                REG_RESIDUE:   r_cfg.crc_good_residue <= i_cfg_wdata[15:0];
                REG_GAP_LIMIT: r_cfg.gap_limit_ticks  <= i_cfg_wdata[15:0];
                REG_OWN_ADDR:  r_cfg.own_address      <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    afp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_item),
        .i_cfg       (r_cfg),
        .i_bank      (r_dq_wp),
        .o_pl_wr     (pl_wr),
        .o_desc_push (dq_push),
        .o_desc      (front_desc)
    );

    afp_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (pl_wr.we),
        .i_waddr (pl_wr.addr),
        .i_wdata (pl_wr.data),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Header queue between the parser and the delivery side. The parser only
    // writes the bank of the free slot, so a frame under delivery is never
    // overwritten.
    always_ff @(posedge i_clk) begin
        if (dq_push) begin
            r_dq[r_dq_wp] <= front_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dq_wp  <= 1'b0;
            r_dq_rp  <= 1'b0;
            r_dq_cnt <= 2'd0;
        end else begin
            if (dq_push) begin
                r_dq_wp <= !r_dq_wp;
            end
            if (dq_pop) begin
                r_dq_rp <= !r_dq_rp;
            end
            r_dq_cnt <= r_dq_cnt + 2'(dq_push) - 2'(dq_pop);
        end
    end

    afp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc_valid (r_dq_cnt != 2'd0),
        .i_desc       (r_dq[r_dq_rp]),
        .i_bank       (r_dq_rp),
        .i_rdata      (rdata),
        .i_pop        (pop),
        .o_raddr      (raddr),
        .o_desc_pop   (dq_pop),
        .o_empty      (empty),
        .o_result     (o_result)
    );

`ifndef NO_ASSERTIONS
    a_dq_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dq_push |-> (r_dq_cnt != 2'd2))
        else $error("frame header pushed into a full queue");

    a_dq_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dq_pop |-> (r_dq_cnt != 2'd0))
        else $error("frame header taken from an empty queue");

    a_dq_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dq_cnt != 2'd3)
        else $error("frame header count out of range");

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");
`endif

endmodule
